@@ rtl/core/uart_transceiver_rx_fifo_unit_assert.svh @@
// ---------------------------------------------------------------------------
// UART transceiver assertion macros
// Shared assertion forms for the UART transceiver core, clocked on i_clk and
// held off during reset.
// ---------------------------------------------------------------------------
`ifndef UART_TRANSCEIVER_RX_FIFO_UNIT_ASSERT_SVH
`define UART_TRANSCEIVER_RX_FIFO_UNIT_ASSERT_SVH

// same-cycle implication
`define URTF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define URTF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/urtf_pkg.sv @@
// ---------------------------------------------------------------------------
// urtf_pkg
// Types, state codes and helper functions for the UART transceiver core.
// ---------------------------------------------------------------------------
package urtf_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_BIT_TIME   = 2'd0;
    localparam logic [1:0] CFG_INVERT     = 2'd1;
    localparam logic [1:0] CFG_PARITY_EN  = 2'd2;
    localparam logic [1:0] CFG_DE_USED    = 2'd3;

    // transmit phases
    localparam logic [3:0] TX_IDLE   = 4'd0;
    localparam logic [3:0] TX_START  = 4'd1;
    localparam logic [3:0] TX_DATA0  = 4'd2;
    localparam logic [3:0] TX_DATA7  = 4'd9;
    localparam logic [3:0] TX_PARITY = 4'd10;
    localparam logic [3:0] TX_STOP   = 4'd11;

    // receive phases (1..8 are the data bits)
    localparam logic [3:0] RX_IDLE   = 4'd0;
    localparam logic [3:0] RX_DATA0  = 4'd1;
    localparam logic [3:0] RX_DATA7  = 4'd8;
    localparam logic [3:0] RX_PARITY = 4'd9;
    localparam logic [3:0] RX_STOP   = 4'd10;

    localparam logic [15:0] BIT_TIME_RST = 16'd8333;
    // ceil(2^17 / 3): exact divide by three for 16-bit values
    localparam logic [16:0] DIV3_RECIP   = 17'd43691;

    typedef struct packed {
        logic [15:0] bit_time;   // effective, never zero
        logic [16:0] rx_first;   // bit_time + bit_time/3
        logic        invert;
        logic        parity_en;
        logic        de_used;
    } t_cfg;

    typedef struct packed {
        logic level;
        logic busy;
    } t_tx_stat;

    typedef struct packed {
        logic pop;
        logic flush;
        logic clr_ovf;
    } t_fifo_cmd;

    typedef struct packed {
        logic       nonempty;
        logic [5:0] count;
        logic       overflow;
    } t_fifo_stat;

    function automatic logic [15:0] eff_bit_time(input logic [15:0] bt);
        eff_bit_time = (bt == 16'd0) ? 16'd1 : bt;
    endfunction

    function automatic logic [16:0] rx_first_load(input logic [15:0] bt);
        logic [15:0] e;
        logic [32:0] prod;
        e    = eff_bit_time(bt);
        prod = 33'(e) * 33'(DIV3_RECIP);
        rx_first_load = 17'(e) + 17'(prod[32:17]);
    endfunction

endpackage

@@ rtl/core/urtf_tx.sv @@
// ---------------------------------------------------------------------------
// urtf_tx
// Transmit framer: start, 8 data bits LSB first, optional even parity, stop.
// ---------------------------------------------------------------------------
module urtf_tx (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  urtf_pkg::t_cfg    i_cfg,
    input  logic              i_send_valid,
    input  logic [7:0]        i_send_byte,
    output urtf_pkg::t_tx_stat o_stat
);
    import urtf_pkg::*;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    logic [7:0]  r_shift, n_shift;
    logic        r_par,   n_par;
    logic [15:0] timer_dec;
    logic        line_raw;

    assign timer_dec = r_timer - 16'd1;

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_shift = r_shift;
        n_par   = r_par;
        if (r_phase == TX_IDLE || r_phase > TX_STOP) begin
            n_phase = TX_IDLE;
            if (i_send_valid) begin
                n_shift = i_send_byte;
                n_par   = 1'b0;
                n_timer = i_cfg.bit_time;
                n_phase = TX_START;
            end
        end else begin
            n_timer = timer_dec;
            if (timer_dec == 16'd0) begin
                n_timer = i_cfg.bit_time;
                if (r_phase inside {[TX_DATA0:TX_DATA7]}) begin
                    n_par   = r_par ^ r_shift[0];
                    n_shift = {1'b0, r_shift[7:1]};
                end
                if (r_phase == TX_DATA7) begin
                    n_phase = i_cfg.parity_en ? TX_PARITY : TX_STOP;
                end else if (r_phase == TX_STOP) begin
                    n_phase = TX_IDLE;
                end else begin
                    n_phase = r_phase + 4'd1;
                end
            end
        end
    end

    // line level follows the updated state
    always_comb begin
        if (n_phase == TX_START) begin
            line_raw = 1'b0;
        end else if (n_phase inside {[TX_DATA0:TX_DATA7]}) begin
            line_raw = n_shift[0];
        end else if (n_phase == TX_PARITY) begin
            line_raw = n_par;
        end else begin
            line_raw = 1'b1;
        end
    end

    assign o_stat.level = line_raw ^ i_cfg.invert;
    assign o_stat.busy  = (n_phase != TX_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= TX_IDLE;
            r_timer <= '0;
            r_shift <= '0;
            r_par   <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_shift <= n_shift;
            r_par   <= n_par;
        end
    end

endmodule

@@ rtl/core/urtf_rx.sv @@
// ---------------------------------------------------------------------------
// urtf_rx
// Receive sampler: start edge detect, 8 data samples, parity/stop wait.
// ---------------------------------------------------------------------------
module urtf_rx (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  urtf_pkg::t_cfg i_cfg,
    input  logic           i_level,
    output logic           o_push,
    output logic [7:0]     o_push_byte
);
    import urtf_pkg::*;

    logic [3:0]  r_phase, n_phase;
    logic [16:0] r_timer, n_timer;
    logic [7:0]  r_shift, n_shift;
    logic        r_prev;
    logic [16:0] timer_dec;
    logic        idle_lvl;

    assign timer_dec = r_timer - 17'd1;
    assign idle_lvl  = ~i_cfg.invert;

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_shift = r_shift;
        o_push  = 1'b0;
        if (r_phase == RX_IDLE || r_phase > RX_STOP) begin
            n_phase = RX_IDLE;
            if (r_prev == idle_lvl && i_level != idle_lvl) begin
                n_timer = i_cfg.rx_first;
                n_phase = RX_DATA0;
            end
        end else begin
            n_timer = timer_dec;
            if (timer_dec == 17'd0) begin
                n_timer = 17'(i_cfg.bit_time);
                if (r_phase <= RX_DATA7) begin
                    n_shift = {i_level ^ i_cfg.invert, r_shift[7:1]};
                    if (r_phase == RX_DATA7) begin
                        n_phase = i_cfg.parity_en ? RX_PARITY : RX_STOP;
                    end else begin
                        n_phase = r_phase + 4'd1;
                    end
                end else if (r_phase == RX_PARITY) begin
                    n_phase = RX_STOP;
                end else begin
                    o_push  = 1'b1;
                    n_phase = RX_IDLE;
                end
            end
        end
    end

    assign o_push_byte = r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= RX_IDLE;
            r_timer <= '0;
            r_shift <= '0;
            r_prev  <= 1'b1;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_shift <= n_shift;
            r_prev  <= i_level;
        end
    end

endmodule

@@ rtl/core/urtf_fifo.sv @@
// ---------------------------------------------------------------------------
// urtf_fifo
// Receive ring FIFO: synchronous store, index control, sticky overflow.
// ---------------------------------------------------------------------------
module urtf_fifo #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  urtf_pkg::t_fifo_cmd  i_cmd,
    input  logic                 i_push,
    input  logic [7:0]           i_push_byte,
    output urtf_pkg::t_fifo_stat o_stat,
    output logic [7:0]           o_head
);
    import urtf_pkg::*;

    localparam int IW = $clog2(FIFO_DEPTH);
    localparam int CW = (IW > 6) ? IW : 6;

    logic [7:0]    mem [FIFO_DEPTH];
    logic [IW-1:0] r_wr_idx, r_rd_idx;
    logic          r_ovf;
    logic [7:0]    r_rd_data;
    logic          r_fwd;
    logic [7:0]    r_fwd_byte;

    logic [IW-1:0] rd1, wr1, wr2;
    logic          ovf1, ovf2, full, push_ok;
    logic [IW:0]   diff;
    logic [IW-1:0] count;
    logic [CW-1:0] count_ext;

    function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
        nxt = (i == IW'(FIFO_DEPTH - 1)) ? '0 : i + IW'(1);
    endfunction

    always_comb begin
        rd1  = r_rd_idx;
        wr1  = r_wr_idx;
        if (i_cmd.pop && r_wr_idx != r_rd_idx) begin
            rd1 = nxt(r_rd_idx);
        end
        if (i_cmd.flush) begin
            rd1 = '0;
            wr1 = '0;
        end
        ovf1    = i_cmd.clr_ovf ? 1'b0 : r_ovf;
        full    = (nxt(wr1) == rd1);
        push_ok = i_push && !full;
        wr2     = push_ok ? nxt(wr1) : wr1;
        ovf2    = ovf1 | (i_push && full);
        diff    = {1'b0, wr2} - {1'b0, rd1};
        count   = diff[IW] ? IW'(diff + (IW+1)'(FIFO_DEPTH)) : diff[IW-1:0];
    end

    assign count_ext       = CW'(count);
    assign o_stat.nonempty = (wr2 != rd1);
    assign o_stat.count    = count_ext[5:0];
    assign o_stat.overflow = ovf2;

    // read-first store; a push into the entry being read is forwarded
    always_ff @(posedge i_clk) begin
        if (i_en && push_ok) begin
            mem[wr1] <= i_push_byte;
        end
        if (i_en) begin
            r_rd_data  <= mem[rd1];
            r_fwd_byte <= i_push_byte;
        end
    end

    assign o_head = r_fwd ? r_fwd_byte : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_ovf    <= 1'b0;
            r_fwd    <= 1'b0;
        end else if (i_en) begin
            r_wr_idx <= wr2;
            r_rd_idx <= rd1;
            r_ovf    <= ovf2;
            r_fwd    <= push_ok && (wr1 == rd1);
        end
    end

endmodule

@@ rtl/core/uart_transceiver_rx_fifo_unit.sv @@
// ---------------------------------------------------------------------------
// uart_transceiver_rx_fifo_unit
// UART transceiver (8 data bits, optional even parity, one stop bit) with a
// receive ring FIFO, driven one clock tick per stream transaction.
// ---------------------------------------------------------------------------
// Each input transaction is one tick of bit timing: it carries the sampled
// receive line plus send, pop, overflow-clear and flush requests, and yields
// exactly one output transaction with the line/enable/busy levels and the
// FIFO head, fill count and overflow flag as they stand after that tick.
// One transaction is taken per clock cycle when the output side keeps up;
// each result passes through the read stage, for the synchronous FIFO store
// read, and then the output register. The receive store is read at the
// updated head index on every tick; a byte pushed into an empty FIFO is
// forwarded past the store. With the output register full and stalled the
// input still takes one more transaction into the read stage before
// s_axis_tready drops. Configuration writes take effect on the next tick and
// are meant for idle periods only.
// ---------------------------------------------------------------------------
module uart_transceiver_rx_fifo_unit #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: [0] rx_level, [1] send_valid, [9:2] send_byte, [10] pop_req,
    //        [11] clear_overflow, [12] flush, [15:13] zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // tdata: [0] tx_level, [1] tx_drive_enable, [2] tx_busy, [10:3] head_byte,
    //        [11] fifo_nonempty, [17:12] fifo_count, [18] overflow_seen,
    //        [23:19] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import urtf_pkg::*;

    `include "uart_transceiver_rx_fifo_unit_assert.svh"

    // config registers
    t_cfg r_cfg;

    // tick enable
    logic s_acc;

    t_tx_stat   tx_stat;
    t_fifo_cmd  fifo_cmd;
    t_fifo_stat fifo_stat;
    logic       rx_push;
    logic [7:0] rx_byte;
    logic [7:0] fifo_head;

    // read stage (store data lands here) and output register
    logic       r_v1;
    t_tx_stat   r_s1_tx;
    logic       r_s1_de;
    t_fifo_stat r_s1_fifo;
    logic       r_v2;
    logic [23:0] r_out;
    logic       adv1;
    logic [7:0] head_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_time  <= BIT_TIME_RST;
            r_cfg.rx_first  <= rx_first_load(BIT_TIME_RST);
            r_cfg.invert    <= 1'b0;
            r_cfg.parity_en <= 1'b1;
            r_cfg.de_used   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BIT_TIME: begin
                    r_cfg.bit_time <= eff_bit_time(i_cfg_data);
                    r_cfg.rx_first <= rx_first_load(i_cfg_data);
                end
                CFG_INVERT:    r_cfg.invert    <= i_cfg_data[0];
                CFG_PARITY_EN: r_cfg.parity_en <= i_cfg_data[0];
                CFG_DE_USED:   r_cfg.de_used   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign adv1          = r_v1 && (!r_v2 || m_axis_tready);
    assign s_axis_tready = !r_v1 || adv1;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign fifo_cmd.pop     = s_axis_tdata[10];
    assign fifo_cmd.flush   = s_axis_tdata[12];
    assign fifo_cmd.clr_ovf = s_axis_tdata[11];

    urtf_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (s_acc),
        .i_cfg        (r_cfg),
        .i_send_valid (s_axis_tdata[1]),
        .i_send_byte  (s_axis_tdata[9:2]),
        .o_stat       (tx_stat)
    );

    urtf_rx u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s_acc),
        .i_cfg       (r_cfg),
        .i_level     (s_axis_tdata[0]),
        .o_push      (rx_push),
        .o_push_byte (rx_byte)
    );

    urtf_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s_acc),
        .i_cmd       (fifo_cmd),
        .i_push      (rx_push),
        .i_push_byte (rx_byte),
        .o_stat      (fifo_stat),
        .o_head      (fifo_head)
    );

    // read stage: status captured with the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_acc) begin
            r_v1 <= 1'b1;
        end else if (adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_tx   <= tx_stat;
            r_s1_de   <= r_cfg.de_used & tx_stat.busy;
            r_s1_fifo <= fifo_stat;
        end
    end

    // empty FIFO shows a zero head
    assign head_sel = r_s1_fifo.nonempty ? fifo_head : 8'd0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv1) begin
            r_v2 <= 1'b1;
        end else if (m_axis_tready) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_out <= {5'd0, r_s1_fifo.overflow, r_s1_fifo.count, r_s1_fifo.nonempty,
                      head_sel, r_s1_tx.busy, r_s1_de, r_s1_tx.level};
        end
    end

    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = r_out;

    // a stalled read stage keeps its transaction and status
    `URTF_ASSERT_NXT(a_s1_hold, r_v1 && !adv1, r_v1 && $stable(r_s1_fifo), "read stage lost data on stall")
    // input stalls only when both stages are occupied
    `URTF_ASSERT_IMP(a_ready_full, !s_axis_tready, r_v1 && r_v2, "input stalled with room in pipeline")
    // drive enable never shows without busy
    `URTF_ASSERT_IMP(a_de_busy, r_v1 && r_s1_de, r_s1_tx.busy, "drive enable outside a frame")
    // a result leaves the read stage into the output register next cycle
    `URTF_ASSERT_NXT(a_s1_to_out, adv1, r_v2, "read stage result not registered")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: UART transceiver with receive FIFO
// Every input transaction is one clock tick of the UART. A cycle-exact model
// in this file predicts the status transaction that each tick produces, and a
// checker compares the results field by field, oldest first. Directed tests
// cover the defaults after reset, the register extremes including a zero bit
// time, transmit and receive frames and the FIFO special cases. A
// back-pressure test and random serial traffic follow, and the run ends with
// a stall-free tail.
// ----------------------------------------------------------------------------
module tb;
    import urtf_pkg::*;

    localparam int LATENCY     = 2;     // tick accepted -> status out
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int WATCHDOG    = 4000;  // cycles with no transaction at all

    // one input transaction, packed as s_axis_tdata (first member is the MSB)
    typedef struct packed {
        logic [2:0] pad;
        logic       flush;
        logic       clr_ovf;
        logic       pop;
        logic [7:0] send_byte;
        logic       send;
        logic       rx_level;
    } t_tick;

    // one result transaction, packed as m_axis_tdata
    typedef struct packed {
        logic [4:0] pad;
        logic       overflow;
        logic [5:0] count;
        logic       nonempty;
        logic [7:0] head;
        logic       busy;
        logic       drive_en;
        logic       tx_level;
    } t_line_status;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data  = '0;
    logic        m_ready = 1'b0;
    logic        cfg_we  = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;

    uart_transceiver_rx_fifo_unit #(
        .FIFO_DEPTH (64)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies and the block's own state
    // ------------------------------------------------------------------
    logic [15:0] bt_cfg;
    logic        inv_cfg, par_cfg, de_cfg;
    logic [3:0]  tx_ph;
    logic [15:0] tx_tmr;
    logic [7:0]  tx_sh;
    logic        tx_par;
    logic [3:0]  rx_ph;
    logic [16:0] rx_tmr;
    logic [7:0]  rx_sh;
    logic        rx_prev;
    logic [7:0]  rx_mem [64];
    logic [5:0]  wr_ix, rd_ix;      // 6-bit wrap matches a depth of 64
    logic        ovf_flag;

    t_line_status status_q[$];      // expected status, oldest first
    int  err_cnt = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;              // no idling on either side
    bit  hold_req = 1'b0;           // ask the sink for one long hold-off
    // per-tick command rates in units of 1/10000
    int  p_send = 0, p_pop = 0, p_clr = 0, p_flush = 0;

    function automatic logic [15:0] ticks_per_bit();
        return (bt_cfg == 16'd0) ? 16'd1 : bt_cfg;
    endfunction

    // Advance the model by one tick and return the status it shows after it.
    function automatic t_line_status next_status(input t_tick t);
        t_line_status s;
        logic [15:0]  bt;
        logic [5:0]   cnt;
        logic         idle_lvl;
        logic         line;
        bt = ticks_per_bit();

        // FIFO commands: pop, then flush (wins), then clear
        if (t.pop && wr_ix != rd_ix)
            rd_ix = rd_ix + 6'd1;
        if (t.flush) begin
            wr_ix = '0;
            rd_ix = '0;
        end
        if (t.clr_ovf)
            ovf_flag = 1'b0;

        // transmitter; a request is only taken while idle
        if (tx_ph == TX_IDLE || tx_ph > TX_STOP) begin
            tx_ph = TX_IDLE;
            if (t.send) begin
                tx_sh  = t.send_byte;
                tx_par = 1'b0;
                tx_tmr = bt;
                tx_ph  = TX_START;
            end
        end else begin
            tx_tmr = tx_tmr - 16'd1;
            if (tx_tmr == 16'd0) begin
                tx_tmr = bt;
                if (tx_ph >= TX_DATA0 && tx_ph <= TX_DATA7) begin
                    tx_par = tx_par ^ tx_sh[0];
                    tx_sh  = tx_sh >> 1;
                end
                if (tx_ph == TX_DATA7)
                    tx_ph = par_cfg ? TX_PARITY : TX_STOP;
                else if (tx_ph == TX_STOP)
                    tx_ph = TX_IDLE;
                else
                    tx_ph = tx_ph + 4'd1;
            end
        end

        // receiver: idle-to-start edge, first sample at 4/3 bit
        idle_lvl = ~inv_cfg;
        if (rx_ph == RX_IDLE || rx_ph > RX_STOP) begin
            rx_ph = RX_IDLE;
            if (rx_prev == idle_lvl && t.rx_level != idle_lvl) begin
                rx_tmr = bt + bt / 3;
                rx_ph  = RX_DATA0;
            end
        end else begin
            rx_tmr = rx_tmr - 17'd1;
            if (rx_tmr == 17'd0) begin
                rx_tmr = 17'(bt);
                if (rx_ph <= RX_DATA7) begin
                    rx_sh = {t.rx_level ^ inv_cfg, rx_sh[7:1]};
                    if (rx_ph == RX_DATA7)
                        rx_ph = par_cfg ? RX_PARITY : RX_STOP;
                    else
                        rx_ph = rx_ph + 4'd1;
                end else if (rx_ph == RX_PARITY) begin
                    rx_ph = RX_STOP;
                end else begin
                    if (6'(wr_ix + 6'd1) != rd_ix) begin
                        rx_mem[wr_ix] = rx_sh;
                        wr_ix = wr_ix + 6'd1;
                    end else begin
                        ovf_flag = 1'b1;
                    end
                    rx_ph = RX_IDLE;
                end
            end
        end
        rx_prev = t.rx_level;

        if (tx_ph == TX_START)
            line = 1'b0;
        else if (tx_ph >= TX_DATA0 && tx_ph <= TX_DATA7)
            line = tx_sh[0];
        else if (tx_ph == TX_PARITY)
            line = tx_par;
        else
            line = 1'b1;

        cnt = 6'(wr_ix - rd_ix);
        s = '0;
        s.tx_level = line ^ inv_cfg;
        s.busy     = (tx_ph != TX_IDLE);
        s.drive_en = de_cfg & s.busy;
        s.head     = (cnt != 6'd0) ? rx_mem[rd_ix] : 8'h00;
        s.nonempty = (cnt != 6'd0);
        s.count    = cnt;
        s.overflow = ovf_flag;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus plumbing
    // ------------------------------------------------------------------

    // Offer one tick, wait for its transaction, then queue its prediction.
    task automatic drive_tick(input t_tick t);
        int gap;
        if (!quiet && $urandom_range(0, 11) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        status_q.push_back(next_status(t));
    endtask

    // Idle line level plus random commands at the current rates.
    function automatic t_tick rand_controls();
        t_tick t;
        t = '0;
        t.rx_level  = ~inv_cfg;
        t.send      = ($urandom_range(0, 9999) < p_send);
        t.send_byte = 8'($urandom_range(0, 255));
        t.pop       = ($urandom_range(0, 9999) < p_pop);
        t.clr_ovf   = ($urandom_range(0, 9999) < p_clr);
        t.flush     = ($urandom_range(0, 9999) < p_flush);
        return t;
    endfunction

    task automatic ctrl_tick(input logic pop, input logic clr, input logic flush);
        t_tick t;
        t = '0;
        t.rx_level = ~inv_cfg;
        t.pop      = pop;
        t.clr_ovf  = clr;
        t.flush    = flush;
        drive_tick(t);
    endtask

    // Idle line, or random levels when noisy.
    task automatic line_ticks(input int n, input bit noisy);
        t_tick t;
        int i;
        for (i = 0; i < n; i++) begin
            t = rand_controls();
            if (noisy)
                t.rx_level = 1'($urandom_range(0, 1));
            drive_tick(t);
        end
    endtask

    // Serial frame on the receive line: one idle tick, start, nbits data
    // bits, optional parity bit, then stop_len ticks of idle level.
    task automatic rx_frame(input logic [7:0] data, input int per, input int nbits,
                            input bit with_par, input logic par_val, input int stop_len);
        t_tick t;
        logic [9:0] seq;
        int len, i, k;
        seq = {par_val, data, 1'b0};
        len = 1 + nbits;
        if (with_par) begin
            seq[len] = par_val;
            len++;
        end
        line_ticks(1, 1'b0);
        for (i = 0; i < len; i++)
            for (k = 0; k < per; k++) begin
                t = rand_controls();
                t.rx_level = seq[i] ^ inv_cfg;
                drive_tick(t);
            end
        line_ticks(stop_len, 1'b0);
    endtask

    // Well-formed frame at the configured rate (a zero bit time is one tick).
    task automatic rx_byte(input logic [7:0] data);
        int per;
        per = int'(ticks_per_bit());
        rx_frame(data, per, 8, par_cfg, ^data, per / 2 + int'($urandom_range(1, per)));
    endtask

    // Stop offering and wait until every queued status has come out.
    task automatic settle();
        s_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_BIT_TIME:  bt_cfg  = val;
            CFG_INVERT:    inv_cfg = val[0];
            CFG_PARITY_EN: par_cfg = val[0];
            CFG_DE_USED:   de_cfg  = val[0];
            default: begin
            end
        endcase
    endtask

    // Let any frame in flight finish, drain, then write all four registers.
    task automatic apply_settings(input logic [15:0] bt, input logic inv,
                                  input logic par, input logic de);
        t_tick t;
        t = '0;
        t.rx_level = ~inv_cfg;
        while (tx_ph != TX_IDLE || rx_ph != RX_IDLE)
            drive_tick(t);
        settle();
        write_reg(CFG_BIT_TIME, bt);
        write_reg(CFG_INVERT, {15'd0, inv});
        write_reg(CFG_PARITY_EN, {15'd0, par});
        write_reg(CFG_DE_USED, {15'd0, de});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values in place; only FIFO commands, no frames at 8333 ticks/bit.
    task automatic test_reset_defaults();
        line_ticks(3, 1'b0);
        ctrl_tick(1'b1, 1'b0, 1'b0);    // pop on empty FIFO
        ctrl_tick(1'b1, 1'b0, 1'b1);    // pop and flush together
        ctrl_tick(1'b0, 1'b1, 1'b0);
    endtask

    // Widest bit time, inverted lines, enable used; idle ticks only.
    task automatic test_config_extremes();
        apply_settings(16'hFFFF, 1'b1, 1'b0, 1'b1);
        line_ticks(6, 1'b0);
        ctrl_tick(1'b1, 1'b1, 1'b1);
    endtask

    // Send request held high: repeats while busy and on the tick a frame
    // ends are dropped, the next idle tick takes a new byte. A zero bit
    // time runs at one tick per bit.
    task automatic test_tx_frames();
        t_tick t;
        int i;
        apply_settings(16'd0, 1'b0, 1'b1, 1'b1);
        for (i = 0; i < 24; i++) begin
            t = '0;
            t.rx_level  = ~inv_cfg;
            t.send      = 1'b1;
            t.send_byte = (i < 12) ? 8'h00 : 8'hFF;
            drive_tick(t);
        end
        apply_settings(16'd2, 1'b1, 1'b0, 1'b0);
        for (i = 0; i < 40; i++) begin
            t = '0;
            t.rx_level  = ~inv_cfg;
            t.send      = 1'b1;
            t.send_byte = (i < 20) ? 8'hA5 : 8'h5A;
            drive_tick(t);
        end
    endtask

    task automatic test_rx_frames();
        apply_settings(16'd1, 1'b0, 1'b1, 1'b0);
        ctrl_tick(1'b1, 1'b0, 1'b0);
        rx_byte(8'h00);
        rx_byte(8'hFF);
        rx_byte(8'hA5);
        ctrl_tick(1'b1, 1'b0, 1'b0);
        ctrl_tick(1'b1, 1'b0, 1'b1);    // flush wins over pop
        ctrl_tick(1'b1, 1'b0, 1'b0);
        apply_settings(16'd3, 1'b1, 1'b0, 1'b0);
        rx_byte(8'h3C);
        rx_byte(8'hFF);
        ctrl_tick(1'b1, 1'b0, 1'b0);
        ctrl_tick(1'b0, 1'b0, 1'b1);
    endtask

    // Sink holds off while ticks keep coming, so the block stalls its input.
    task automatic test_backpressure();
        apply_settings(16'd2, 1'b0, 1'b1, 1'b0);
        p_send = 2000;
        p_pop  = 1000;
        hold_req = 1'b1;
        while (hold_req)
            line_ticks(1, 1'b0);
        rx_byte(8'h81);
        rx_byte(8'h7E);
        p_send = 0;
        p_pop  = 0;
    endtask

    // Mostly well-formed frames with random content; some off-rate or cut
    // frames, idle stretches and line noise.
    task automatic test_random();
        int ph, seg, kind;
        int pop_rates[4] = '{0, 500, 1500, 4000};
        for (ph = 0; ph < 2; ph++) begin
            apply_settings((ph == 0) ? 16'd1 : 16'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            p_send  = $urandom_range(0, 3000);
            p_pop   = pop_rates[$urandom_range(0, 3)];
            p_clr   = $urandom_range(0, 200);
            p_flush = $urandom_range(0, 200);
            for (seg = 0; seg < 3; seg++) begin
                kind = $urandom_range(0, 19);
                if (kind < 15)
                    rx_byte(8'($urandom_range(0, 255)));
                else if (kind < 17)
                    rx_frame(8'($urandom_range(0, 255)),
                             int'(ticks_per_bit()) + int'($urandom_range(0, 2)) - 1,
                             $urandom_range(0, 8), par_cfg, 1'($urandom_range(0, 1)),
                             $urandom_range(1, ticks_per_bit()));
                else if (kind < 19)
                    line_ticks($urandom_range(1, 12), 1'b0);
                else
                    line_ticks($urandom_range(1, 8), 1'b1);
            end
        end
    endtask

    // Last stretch with no idling on either side.
    task automatic test_quiet_tail();
        int i;
        quiet = 1'b1;
        apply_settings(16'd1, 1'b0, 1'b1, 1'b1);
        p_send  = 3000;
        p_pop   = 3000;
        p_clr   = 100;
        p_flush = 0;
        for (i = 0; i < 5; i++)
            rx_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial begin : sink
        int n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: each result transaction against the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_line_status got, want;
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            got = m_axis_tdata;
            if (status_q.size() == 0) begin
                err_cnt++;
                $display("%0t: result expected none, got %h", $time, got);
            end else begin
                want = status_q.pop_front();
                check_field("tx_level", want.tx_level, got.tx_level);
                check_field("tx_drive_enable", want.drive_en, got.drive_en);
                check_field("tx_busy", want.busy, got.busy);
                check_field("head_byte", want.head, got.head);
                check_field("fifo_nonempty", want.nonempty, got.nonempty);
                check_field("fifo_count", want.count, got.count);
                check_field("overflow_seen", want.overflow, got.overflow);
            end
        end
    end

    // Watchdog: cycles in which neither side moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // model state after reset
        bt_cfg   = BIT_TIME_RST;
        inv_cfg  = 1'b0;
        par_cfg  = 1'b1;
        de_cfg   = 1'b0;
        tx_ph    = TX_IDLE;
        tx_tmr   = '0;
        tx_sh    = '0;
        tx_par   = 1'b0;
        rx_ph    = RX_IDLE;
        rx_tmr   = '0;
        rx_sh    = '0;
        rx_prev  = 1'b1;
        wr_ix    = '0;
        rd_ix    = '0;
        ovf_flag = 1'b0;
        foreach (rx_mem[j])
            rx_mem[j] = 8'h00;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_config_extremes();
        test_tx_frames();
        test_rx_frames();
        test_backpressure();
        test_random();
        test_quiet_tail();
        settle();

        if (err_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/urtf_pkg.sv
rtl/core/urtf_tx.sv
rtl/core/urtf_rx.sv
rtl/core/urtf_fifo.sv
rtl/core/uart_transceiver_rx_fifo_unit.sv
bench/tb.sv
